### src/earliest_free_worker_scheduler_core_defines.svh
// Assertion macros for the earliest-free-worker scheduler checker.
// Included by the checker file only; depends on nothing else.
`ifndef EARLIEST_FREE_WORKER_SCHEDULER_CORE_DEFINES_SVH
`define EARLIEST_FREE_WORKER_SCHEDULER_CORE_DEFINES_SVH

// General property check, clocked on the rising edge, quiet during reset.
`define EFWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A signal must hold its value in the cycle after a condition is seen.
`define EFWS_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

### src/efws_pkg.sv
// Shared types and constants of the earliest-free-worker scheduler.
// No dependencies; imported by efws_alu, efws_seq, the top level and the checker.
package efws_pkg;

    localparam int TIME_W   = 48;
    localparam int DUR_W    = 32;
    localparam int WORKER_W = 4;
    localparam int NW_W     = 5;

    localparam logic [NW_W-1:0]   NW_RESET = 5'd16;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_state;

    // Controls from the sequencer to the compare/add unit.
    typedef struct packed {
        logic load_dur;
        logic cmp_en;
        logic first;
    } t_alu_ctrl;

    // Controls from the sequencer to the memory and result register.
    typedef struct packed {
        logic clear;
        logic wr_en;
        logic done;
    } t_seq_ctrl;

endpackage

### src/efws_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module efws_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/efws_alu.sv
// Shared compare and saturating-add unit of the scheduler.
// Depends on efws_pkg.
module efws_alu
    import efws_pkg::*;
(
    input  logic              i_clk,
    input  t_alu_ctrl         i_ctrl,
    input  logic [TIME_W-1:0] i_rd_data,
    input  logic [DUR_W-1:0]  i_duration,
    output logic              o_take,
    output logic [TIME_W-1:0] o_start,
    output logic [TIME_W-1:0] o_new_time,
    output logic              o_sat
);

    logic [TIME_W-1:0] r_best_time;
    logic [DUR_W-1:0]  r_dur;
    logic              less;
    logic [TIME_W:0]   sum;

    // One comparator decides whether the arriving free time is the new minimum.
    assign less   = i_rd_data < r_best_time;
    assign o_take = i_ctrl.cmp_en && (i_ctrl.first || less);

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_best_time <= i_rd_data;
        end
        if (i_ctrl.load_dur) begin
            r_dur <= i_duration;
        end
    end

    // Saturating add of the job duration onto the chosen free time.
    assign sum        = {1'b0, r_best_time} + {{(TIME_W + 1 - DUR_W){1'b0}}, r_dur};
    assign o_sat      = sum[TIME_W];
    assign o_new_time = o_sat ? TIME_MAX : sum[TIME_W-1:0];
    assign o_start    = r_best_time;

endmodule

### src/efws_seq.sv
// Sequencer of the scheduler: clearing sweep, minimum scan and write-back.
// Depends on efws_pkg.
module efws_seq
    import efws_pkg::*;
#(
    parameter int NUM_WORKERS = 16,
    parameter int IW          = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [NW_W-1:0] i_num_workers,
    input  logic            i_out_busy,
    input  logic            i_take,
    output logic            o_in_stall,
    output t_alu_ctrl       o_alu_ctrl,
    output t_seq_ctrl       o_seq_ctrl,
    output logic [IW-1:0]   o_rd_addr,
    output logic [IW-1:0]   o_wr_addr,
    output logic [IW-1:0]   o_best_idx
);

    localparam int            CW         = $clog2(NUM_WORKERS + 1);
    localparam logic [IW-1:0] LAST_ENTRY = IW'(NUM_WORKERS - 1);

    t_state        r_state, n_state;
    logic [IW-1:0] r_clr_idx, n_clr_idx;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic [IW-1:0] r_cmp_idx, n_cmp_idx;
    logic [IW-1:0] r_last, n_last;
    logic [IW-1:0] r_best_idx;
    logic [CW-1:0] act_cnt;
    logic [CW-1:0] act_m1;

    // Active worker count: zero acts as one, and the count is capped at the pool size.
    always_comb begin
        if (i_num_workers == '0) begin
            act_cnt = CW'(1);
        end else if (int'(i_num_workers) > NUM_WORKERS) begin
            act_cnt = CW'(NUM_WORKERS);
        end else begin
            act_cnt = CW'(i_num_workers);
        end
        act_m1 = act_cnt - CW'(1);
    end

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_rd_idx  <= '0;
            r_cmp_idx <= '0;
            r_last    <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_rd_idx  <= n_rd_idx;
            r_cmp_idx <= n_cmp_idx;
            r_last    <= n_last;
        end
    end

    // The index of the current minimum follows the comparator.
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_best_idx <= r_cmp_idx;
        end
    end

    // Next state and control outputs.
    always_comb begin
        n_state    = r_state;
        n_clr_idx  = r_clr_idx;
        n_rd_idx   = r_rd_idx;
        n_cmp_idx  = r_cmp_idx;
        n_last     = r_last;
        o_in_stall = 1'b1;
        o_alu_ctrl = '0;
        o_seq_ctrl = '0;
        o_rd_addr  = r_rd_idx;
        o_wr_addr  = r_best_idx;
        case (r_state)
            ST_CLEAR: begin
                o_seq_ctrl.clear = 1'b1;
                o_seq_ctrl.wr_en = 1'b1;
                o_wr_addr        = r_clr_idx;
                if (r_clr_idx == LAST_ENTRY) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + IW'(1);
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_rd_addr  = '0;
                if (i_in_valid) begin
                    o_alu_ctrl.load_dur = 1'b1;
                    n_last    = IW'(act_m1);
                    n_cmp_idx = '0;
                    n_rd_idx  = (act_m1 == '0) ? '0 : IW'(1);
                    n_state   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Data for r_cmp_idx arrives while the next read is issued.
                o_alu_ctrl.cmp_en = 1'b1;
                o_alu_ctrl.first  = (r_cmp_idx == '0);
                if (r_cmp_idx == r_last) begin
                    n_state = ST_WRITE;
                end else begin
                    n_cmp_idx = r_cmp_idx + IW'(1);
                    if (r_rd_idx != r_last) begin
                        n_rd_idx = r_rd_idx + IW'(1);
                    end
                end
            end
            ST_WRITE: begin
                // Wait for room in the result register, then write back.
                if (!i_out_busy) begin
                    o_seq_ctrl.wr_en = 1'b1;
                    o_seq_ctrl.done  = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_best_idx = r_best_idx;

endmodule

### src/earliest_free_worker_scheduler_core.sv
// Top level of the earliest-free-worker scheduler.
// Depends on efws_pkg, efws_ram, efws_alu and efws_seq.
//
// Each input transfer carries one job duration. The block scans the free
// times of the first num_workers workers, picks the earliest (lowest index
// on a tie), returns that worker and the job's start time, and adds the
// duration to the worker's free time, clipping at 2^48-1 with o_saturated.
// Both channels use valid/stall. The configuration register num_workers is
// written by i_cfg_we/i_cfg_data; the user must write it only while the
// block is idle, which the block itself does not enforce. An item passes
// through an accept state, a scan of the active entries through the single
// read port of the free-time memory and the shared comparator, and a
// write-back state; no new item is taken until write-back is done.
// After reset a clearing sweep writes zero to all NUM_WORKERS entries, one
// per cycle, with o_in_stall high; num_workers resets to 16.
// The result sits in an output register; a stall from the receiver holds it,
// and a finished item then waits in write-back until the register frees.
module earliest_free_worker_scheduler_core
    import efws_pkg::*;
#(
    parameter int NUM_WORKERS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [DUR_W-1:0]    i_duration,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [WORKER_W-1:0] o_worker,
    output logic [TIME_W-1:0]   o_start_time,
    output logic                o_saturated,
    input  logic                i_cfg_we,
    input  logic [NW_W-1:0]     i_cfg_data
);

    localparam int IW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;

    logic [NW_W-1:0]     r_num_workers;
    logic                r_out_valid;
    logic [WORKER_W-1:0] r_worker;
    logic [TIME_W-1:0]   r_start;
    logic                r_sat;

    t_alu_ctrl         alu_ctrl;
    t_seq_ctrl         seq_ctrl;
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     wr_addr;
    logic [IW-1:0]     best_idx;
    logic [TIME_W-1:0] rd_data;
    logic [TIME_W-1:0] wr_data;
    logic [TIME_W-1:0] new_time;
    logic [TIME_W-1:0] start;
    logic              sat;
    logic              take;
    logic              out_busy;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_workers <= NW_RESET;
        end else if (i_cfg_we) begin
            r_num_workers <= i_cfg_data;
        end
    end

    assign out_busy = r_out_valid && i_out_stall;

    efws_seq #(
        .NUM_WORKERS (NUM_WORKERS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_num_workers (r_num_workers),
        .i_out_busy    (out_busy),
        .i_take        (take),
        .o_in_stall    (o_in_stall),
        .o_alu_ctrl    (alu_ctrl),
        .o_seq_ctrl    (seq_ctrl),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .o_best_idx    (best_idx)
    );

    efws_alu u_alu (
        .i_clk      (i_clk),
        .i_ctrl     (alu_ctrl),
        .i_rd_data  (rd_data),
        .i_duration (i_duration),
        .o_take     (take),
        .o_start    (start),
        .o_new_time (new_time),
        .o_sat      (sat)
    );

    // The clearing sweep writes zero; write-back stores the updated free time.
    assign wr_data = seq_ctrl.clear ? '0 : new_time;

    efws_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_WORKERS)
    ) u_free_ram (
        .i_clk     (i_clk),
        .i_wr_en   (seq_ctrl.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register: loaded at write-back, cleared once its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_ctrl.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_ctrl.done) begin
            r_worker <= WORKER_W'(best_idx);
            r_start  <= start;
            r_sat    <= sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_worker     = r_worker;
    assign o_start_time = r_start;
    assign o_saturated  = r_sat;

endmodule

### src/efws_chk.sv
// Port-level checker for the earliest-free-worker scheduler, bound to the top.
// Depends on efws_pkg and earliest_free_worker_scheduler_core_defines.svh.
`include "earliest_free_worker_scheduler_core_defines.svh"

module efws_chk
    import efws_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [TIME_W-1:0]   o_start_time
);

    // A stalled result stays valid and keeps its payload.
    `EFWS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "stalled result dropped")
    `EFWS_ASSERT_HOLD(a_start_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_start_time, "stalled start time changed")

    // After taking a job the block is busy scanning.
    `EFWS_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "input taken during a scan")

    // A new result only comes out of work in progress, never from idle.
    `EFWS_ASSERT(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall), "result appeared while idle")

endmodule

bind earliest_free_worker_scheduler_core efws_chk u_efws_chk (.*);
